// ===== rtl/four_axis_pid_velocity_core_defines.svh =====
// assertion macros shared by the pid velocity core rtl
`ifndef FOUR_AXIS_PID_VELOCITY_CORE_DEFINES_SVH
`define FOUR_AXIS_PID_VELOCITY_CORE_DEFINES_SVH

// clocked check, masked while reset is asserted
`define FAPV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// clocked check that also holds across reset
`define FAPV_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== rtl/fapv_pkg.sv =====
// shared types, widths and constants of the pid velocity core
`default_nettype none

package fapv_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int INTEG_W   = 24;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int AXES      = 4;

    // integral bound of +/-100.0 in q16.16
    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 24'sd6553600;

    // gain set of one axis, unsigned q2.14 each
    typedef struct packed {
        logic [GAIN_W-1:0] p;
        logic [GAIN_W-1:0] i;
        logic [GAIN_W-1:0] d;
    } pid_gains_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_XY_GAINS   = 3'd0,
        REG_Z_GAINS    = 3'd1,
        REG_YAW_GAINS  = 3'd2,
        REG_TARGET_X   = 3'd3,
        REG_TARGET_Y   = 3'd4,
        REG_TARGET_Z   = 3'd5,
        REG_TARGET_YAW = 3'd6
    } cfg_reg_t;

    // reset gains: xy p 0.4 i 0.01 d 0.05, z p 0.1, yaw p 0.2
    localparam logic [CFG_W-1:0] XY_GAINS_RST  = 48'h199A_00A4_0333;
    localparam logic [CFG_W-1:0] Z_GAINS_RST   = 48'h0666_0000_0000;
    localparam logic [CFG_W-1:0] YAW_GAINS_RST = 48'h0CCD_0000_0000;

endpackage

`default_nettype wire

// ===== rtl/four_axis_pid_velocity_core.sv =====
// top level of the four-axis pid velocity core
`default_nettype none

`include "four_axis_pid_velocity_core_defines.svh"

// Four-axis PID core: each pose transaction (x, y, z, yaw, Q16.16) yields one drive
// transaction. A new pose is taken every cycle unless the result side stalls; each pose
// passes the input register, then the result register. The cycle is set by one lane's path:
// saturated error, clamped integral, three 17-bit gain multiplies and their rounded sum.
// Lane state (integral, previous error) updates as a pose leaves the input register, so
// back-pressure on the result side stalls the state too. Configuration writes are always
// ready and must be issued only while no pose is in flight; indexes above 6 are dropped.
module four_axis_pid_velocity_core (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // pose input
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [4*fapv_pkg::DATA_W-1:0]         s_tdata,  // current_x, current_y, current_z, current_yaw
    // drive output
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [4*fapv_pkg::DATA_W-1:0]              m_tdata,  // drive_x, drive_y, drive_z, drive_yaw
    // configuration write
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [fapv_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fapv_pkg::CFG_W-1:0]            cfg_data
);
    import fapv_pkg::*;

    logic [CFG_W-1:0]          xy_gains_reg;
    logic [CFG_W-1:0]          z_gains_reg;
    logic [CFG_W-1:0]          yaw_gains_reg;
    logic signed [DATA_W-1:0]  target_reg [AXES];
    pid_gains_t                lane_gains [AXES];

    logic                      in_valid_reg;
    logic [AXES*DATA_W-1:0]    in_data_reg;
    logic                      out_valid_reg;
    logic [AXES*DATA_W-1:0]    out_data_reg;
    logic [AXES*DATA_W-1:0]    drive_all;
    logic                      advance;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xy_gains_reg  <= XY_GAINS_RST;
            z_gains_reg   <= Z_GAINS_RST;
            yaw_gains_reg <= YAW_GAINS_RST;
            for (int k = 0; k < AXES; k++) begin
                target_reg[k] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_XY_GAINS:   xy_gains_reg  <= cfg_data;
                REG_Z_GAINS:    z_gains_reg   <= cfg_data;
                REG_YAW_GAINS:  yaw_gains_reg <= cfg_data;
                REG_TARGET_X:   target_reg[0] <= cfg_data[DATA_W-1:0];
                REG_TARGET_Y:   target_reg[1] <= cfg_data[DATA_W-1:0];
                REG_TARGET_Z:   target_reg[2] <= cfg_data[DATA_W-1:0];
                REG_TARGET_YAW: target_reg[3] <= cfg_data[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    // x and y share one gain set
    assign lane_gains[0] = pid_gains_t'(xy_gains_reg);
    assign lane_gains[1] = pid_gains_t'(xy_gains_reg);
    assign lane_gains[2] = pid_gains_t'(z_gains_reg);
    assign lane_gains[3] = pid_gains_t'(yaw_gains_reg);

    // pipeline flow: pose moves to the result register when that is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    // one pid lane per axis
    for (genvar g = 0; g < AXES; g++) begin : g_lane
        fapv_axis u_axis (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step_en (advance),
            .target  (target_reg[g]),
            .current (in_data_reg[g*DATA_W +: DATA_W]),
            .gains   (lane_gains[g]),
            .drive   (drive_all[g*DATA_W +: DATA_W])
        );
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= drive_all;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `FAPV_ASSERT_RST(a_rst_empty, !aresetn |=> !m_tvalid && !in_valid_reg, "pipeline not empty after reset")
    `FAPV_ASSERT(a_out_source, $rose(m_tvalid) |-> $past(advance), "result appeared without a pose")
    `FAPV_ASSERT(a_no_stall_free, in_valid_reg && !out_valid_reg |-> advance && s_tready, "pose stuck with result register free")

endmodule

`default_nettype wire

// ===== rtl/fapv_axis.sv =====
// one pid lane: error, clamped integral, derivative and saturated drive
`default_nettype none

`include "four_axis_pid_velocity_core_defines.svh"

module fapv_axis (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 step_en,
    input  wire logic signed [fapv_pkg::DATA_W-1:0]   target,
    input  wire logic signed [fapv_pkg::DATA_W-1:0]   current,
    input  wire fapv_pkg::pid_gains_t                 gains,
    output logic signed [fapv_pkg::DATA_W-1:0]        drive
);
    import fapv_pkg::*;

    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [DATA_W-1:0]  prev_err_reg;

    logic signed [DATA_W:0]    diff;
    logic signed [DATA_W-1:0]  err;
    logic signed [DATA_W:0]    integ_sum;
    logic signed [DATA_W:0]    deriv;
    logic signed [48:0]        prod_p;
    logic signed [40:0]        prod_i;
    logic signed [49:0]        prod_d;
    logic signed [51:0]        acc;
    logic signed [37:0]        scaled;

    // error, saturated to 32 bits
    always_comb begin
        diff = {target[DATA_W-1], target} - {current[DATA_W-1], current};
        if (diff[DATA_W] != diff[DATA_W-1]) begin
            err = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            err = diff[DATA_W-1:0];
        end
    end

    // integral with clamp at +/-100.0
    always_comb begin
        integ_sum = (DATA_W+1)'(integ_reg) + (DATA_W+1)'(err);
        if (integ_sum >= (DATA_W+1)'(INTEG_LIMIT)) begin
            integ_next = INTEG_LIMIT;
        end else if (integ_sum <= -(DATA_W+1)'(INTEG_LIMIT)) begin
            integ_next = -INTEG_LIMIT;
        end else begin
            integ_next = integ_sum[INTEG_W-1:0];
        end
    end

    assign deriv = (DATA_W+1)'(err) - (DATA_W+1)'(prev_err_reg);

    // three gain products, summed exactly
    assign prod_p = $signed({1'b0, gains.p}) * err;
    assign prod_i = $signed({1'b0, gains.i}) * integ_next;
    assign prod_d = $signed({1'b0, gains.d}) * deriv;
    assign acc    = 52'(prod_p) + 52'(prod_i) + 52'(prod_d) + 52'sd8192;

    // round to q16.16 (ties up) and saturate
    always_comb begin
        scaled = acc[51:14];
        if (scaled[37:31] != {7{scaled[31]}}) begin
            drive = scaled[37] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            drive = scaled[DATA_W-1:0];
        end
    end

    // lane state advances once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end else if (step_en) begin
            integ_reg    <= integ_next;
            prev_err_reg <= err;
        end
    end

    `FAPV_ASSERT(a_integ_bound, (integ_reg <= INTEG_LIMIT) && (integ_reg >= -INTEG_LIMIT), "integral out of bound")
    `FAPV_ASSERT(a_state_hold, !step_en |=> $stable(integ_reg) && $stable(prev_err_reg), "lane state moved without a step")
    `FAPV_ASSERT_RST(a_state_rst, !aresetn |=> (integ_reg == '0) && (prev_err_reg == '0), "lane state not cleared by reset")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench of the four-axis pid velocity core: directed and random poses
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fapv_pkg::*;

    // index outside the register map, the core drops it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [DATA_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN     = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_FIFTY   = 32'h0032_0000;
    localparam logic [DATA_W-1:0] Q_ZERO    = 32'h0000_0000;
    localparam logic [DATA_W-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;
    localparam logic [GAIN_W-1:0] GAIN_ONE  = 16'h4000;

    localparam int RANDOM_PHASES    = 10;
    localparam int POSES_PER_PHASE  = 125;

    // expected drives of the pid lanes, with their own copy of gains, set points and state
    class drive_scoreboard;
        localparam longint INTEG_BOUND = 64'sd6553600;
        localparam longint DRIVE_MAX   = 64'sd2147483647;
        localparam longint DRIVE_MIN   = -64'sd2147483648;

        pid_gains_t          xy_gains;
        pid_gains_t          z_gains;
        pid_gains_t          yaw_gains;
        longint              setpoint [AXES];
        longint              integral [AXES];
        longint              last_error [AXES];
        logic [4*DATA_W-1:0] expected_drives [$];
        string               drive_field [AXES];
        int                  failures;

        function new();
            xy_gains    = XY_GAINS_RST;
            z_gains     = Z_GAINS_RST;
            yaw_gains   = YAW_GAINS_RST;
            foreach (setpoint[a]) begin
                setpoint[a]   = 0;
                integral[a]   = 0;
                last_error[a] = 0;
            end
            drive_field = '{"drive_x", "drive_y", "drive_z", "drive_yaw"};
            failures    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_XY_GAINS:   xy_gains    = data;
                REG_Z_GAINS:    z_gains     = data;
                REG_YAW_GAINS:  yaw_gains   = data;
                REG_TARGET_X:   setpoint[0] = longint'($signed(data[DATA_W-1:0]));
                REG_TARGET_Y:   setpoint[1] = longint'($signed(data[DATA_W-1:0]));
                REG_TARGET_Z:   setpoint[2] = longint'($signed(data[DATA_W-1:0]));
                REG_TARGET_YAW: setpoint[3] = longint'($signed(data[DATA_W-1:0]));
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > DRIVE_MAX)
                return DRIVE_MAX;
            if (v < DRIVE_MIN)
                return DRIVE_MIN;
            return v;
        endfunction

        // one lane: saturated error, clamped integral, difference, rounded weighted sum
        function longint lane_drive(int axis, pid_gains_t g, logic [DATA_W-1:0] measured);
            longint err;
            longint sum;
            longint acc;
            err = clip32(setpoint[axis] - longint'($signed(measured)));
            sum = integral[axis] + err;
            if (sum >= INTEG_BOUND)
                sum = INTEG_BOUND;
            else if (sum <= -INTEG_BOUND)
                sum = -INTEG_BOUND;
            acc = longint'(g.p) * err + longint'(g.i) * sum
                + longint'(g.d) * (err - last_error[axis]);
            integral[axis]   = sum;
            last_error[axis] = err;
            // arithmetic shift floors, so adding half an lsb rounds ties upward
            return clip32((acc + 64'sd8192) >>> 14);
        endfunction

        function void note_pose(logic [4*DATA_W-1:0] pose);
            logic [4*DATA_W-1:0] drive;
            pid_gains_t          g;
            int                  a;
            for (a = 0; a < AXES; a++) begin
                g = (a < 2) ? xy_gains : (a == 2) ? z_gains : yaw_gains;
                drive[a*DATA_W +: DATA_W] = DATA_W'(lane_drive(a, g, pose[a*DATA_W +: DATA_W]));
            end
            expected_drives.push_back(drive);
        endfunction

        function void check_drive(logic [4*DATA_W-1:0] drive);
            logic [4*DATA_W-1:0] want;
            int                  a;
            if (expected_drives.size() == 0) begin
                $error("drive transaction with no pose outstanding: %h", drive);
                failures++;
                return;
            end
            want = expected_drives.pop_front();
            for (a = 0; a < AXES; a++) begin
                if (drive[a*DATA_W +: DATA_W] !== want[a*DATA_W +: DATA_W]) begin
                    $error("%s expected %0d actual %0d", drive_field[a],
                           $signed(want[a*DATA_W +: DATA_W]),
                           $signed(drive[a*DATA_W +: DATA_W]));
                    failures++;
                end
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [4*DATA_W-1:0]   s_tdata   = '0;   // current_x, current_y, current_z, current_yaw
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [4*DATA_W-1:0]   m_tdata;          // drive_x, drive_y, drive_z, drive_yaw
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    drive_scoreboard       drive_model = new();

    int                    send_gap_pct = 0;
    int                    stall_pct    = 0;
    int                    stall_left   = 0;
    logic [DATA_W-1:0]     goal [AXES];
    logic [DATA_W-1:0]     track [AXES];

    four_axis_pid_velocity_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(11, 0);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // observe every transaction on the three channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                drive_model.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                drive_model.note_pose(s_tdata);
            if (m_tvalid && m_tready)
                drive_model.check_drive(m_tdata);
        end
    end

    // offer one pose, optionally after an idle burst, and hold it until taken
    task automatic send_pose(input logic [4*DATA_W-1:0] pose);
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pose;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (drive_model.pending() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // full register set, written only once the core holds no pose
    task automatic program_regs(input logic [CFG_W-1:0] xy, input logic [CFG_W-1:0] z,
                                input logic [CFG_W-1:0] yaw, input logic [CFG_W-1:0] tx,
                                input logic [CFG_W-1:0] ty, input logic [CFG_W-1:0] tz,
                                input logic [CFG_W-1:0] tw, input bit add_junk);
        wait_drained();
        if (add_junk)
            cfg_write(REG_UNUSED, {16'($urandom), 32'($urandom)});
        cfg_write(REG_XY_GAINS, xy);
        cfg_write(REG_Z_GAINS, z);
        cfg_write(REG_YAW_GAINS, yaw);
        cfg_write(REG_TARGET_X, tx);
        cfg_write(REG_TARGET_Y, ty);
        cfg_write(REG_TARGET_Z, tz);
        cfg_write(REG_TARGET_YAW, tw);
        cfg_valid <= 1'b0;
        goal[0] = tx[DATA_W-1:0];
        goal[1] = ty[DATA_W-1:0];
        goal[2] = tz[DATA_W-1:0];
        goal[3] = tw[DATA_W-1:0];
        foreach (track[a])
            track[a] = goal[a];
    endtask

    function automatic logic [CFG_W-1:0] rand_gains();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return {16'($urandom), 32'($urandom)};
            default: return {16'($urandom_range(GAIN_ONE)), 16'($urandom_range(GAIN_ONE / 16)),
                             16'($urandom_range(GAIN_ONE / 2))};
        endcase
    endfunction

    // set point with junk above bit 31, which the core must ignore
    function automatic logic [CFG_W-1:0] rand_target();
        logic [DATA_W-1:0] value;
        case ($urandom_range(5))
            0: value = '0;
            1: value = Q_MAX;
            2: value = Q_MIN;
            3: value = $urandom;
            default: value = 32'($urandom_range(32'd65536000)) - 32'd32768000;
        endcase
        return {16'($urandom), value};
    endfunction

    // mostly a drifting pose around the set point, with jumps, noise and extremes
    function automatic logic [DATA_W-1:0] next_coord(int axis);
        int r;
        r = $urandom_range(99);
        if (r < 75) begin
            track[axis] = track[axis] + 32'($urandom_range(32'd524288)) - 32'd262144;
            return track[axis];
        end
        if (r < 85) begin
            track[axis] = goal[axis] + 32'($urandom_range(32'd19660800)) - 32'd9830400;
            return track[axis];
        end
        if (r < 95)
            return $urandom;
        case ($urandom_range(3))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    initial begin
        int phase;
        int n;
        logic [4*DATA_W-1:0] pose;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset gains and zero set points: extremes, unit steps, integral into both bounds
        send_gap_pct = 30;
        stall_pct    = 10;
        foreach (goal[a])
            goal[a] = '0;
        send_pose('0);
        send_pose({Q_MAX, Q_MAX, Q_MAX, Q_MAX});
        send_pose({Q_MIN, Q_MIN, Q_MIN, Q_MIN});
        send_pose({-Q_ONE, Q_ONE, -Q_ONE, Q_ONE});
        send_pose({32'd1, Q_NEG_LSB, 32'd1, Q_NEG_LSB});
        repeat (3) send_pose({Q_FIFTY, Q_FIFTY, Q_FIFTY, Q_FIFTY});
        repeat (5) send_pose({-Q_FIFTY, -Q_FIFTY, -Q_FIFTY, -Q_FIFTY});

        // largest gains and extreme set points: error and drive overflow both ways
        program_regs('1, '1, '1, {16'hFFFF, Q_MAX}, {16'h0000, Q_MIN}, '0,
                     {16'h5A5A, Q_ONE}, 1'b1);
        send_pose({Q_MIN, Q_MIN, Q_MAX, Q_MIN});
        send_pose({Q_MAX, Q_MAX, Q_MIN, Q_MAX});
        send_pose({Q_MAX, Q_MAX, Q_MIN, Q_MAX});
        send_pose('0);
        send_pose({Q_ONE, Q_MIN, Q_MAX, -Q_ONE});

        // all gains zero
        program_regs('0, '0, '0, {16'h1234, -Q_ONE}, {16'hFFFF, Q_MAX}, {16'h8000, Q_MIN},
                     '0, 1'b1);
        send_pose({Q_MAX, Q_MIN, Q_ZERO, Q_ONE});
        send_pose({32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)});

        // random phases, each under its own setting
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES - 1) begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end else begin
                send_gap_pct = (phase % 3 == 2) ? 0 : $urandom_range(60);
                stall_pct    = (phase % 4 == 3) ? 0 : $urandom_range(40);
            end
            if (phase == 0)
                program_regs('1, '1, '1, rand_target(), rand_target(), rand_target(),
                             rand_target(), 1'($urandom_range(1)));
            else if (phase == 1)
                program_regs('0, '0, '0, rand_target(), rand_target(), rand_target(),
                             rand_target(), 1'($urandom_range(1)));
            else
                program_regs(rand_gains(), rand_gains(), rand_gains(), rand_target(),
                             rand_target(), rand_target(), rand_target(),
                             1'($urandom_range(1)));
            for (n = 0; n < POSES_PER_PHASE; n++) begin
                pose = {next_coord(3), next_coord(2), next_coord(1), next_coord(0)};
                send_pose(pose);
                // now and then the sender holds off until the core has emptied
                if ($urandom_range(99) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (drive_model.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
